// File: sv/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg: shared constants, types and helpers of the radix digit converter
// Field widths, the digit store geometry and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int ValueBits   = 31;
	localparam int RadixBits   = 6;
	localparam int DigitBits   = 6;
	localparam int CharBits    = 7;
	localparam int MaxDigits   = 31;
	localparam int StoreDepth  = MaxDigits + 1;
	localparam int StoreAw     = $clog2(StoreDepth);
	localparam int BitCntW     = $clog2(ValueBits);
	localparam int TrialW      = RadixBits + 1;
	localparam int InDataW     = ((ValueBits + RadixBits + 7) / 8) * 8;
	localparam int OutDataW    = ((DigitBits + CharBits + 7) / 8) * 8;

	localparam logic [RadixBits-1:0] RadixMin = RadixBits'(2);
	localparam logic [RadixBits-1:0] RadixMax = RadixBits'(36);

	localparam logic [CharBits-1:0] CharZero    = CharBits'(48);
	localparam logic [CharBits-1:0] CharLetterA = CharBits'(55);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// ASCII character of a digit: 0-9 then A-Z
	function automatic logic [CharBits-1:0] digit_char(input logic [DigitBits-1:0] d);
		logic [CharBits-1:0] dx;
		dx = CharBits'(d);
		if (d < DigitBits'(10)) begin
			return CharZero + dx;
		end else begin
			return CharLetterA + dx;
		end
	endfunction

endpackage
`default_nettype wire

// File: sv/radix_digit_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter_core: integer to base-N digits, base 2 to 36
// Bit-serial restoring division produces the digits least significant first
// into a small store; they are then sent most significant first.
// ----------------------------------------------------------------------------
// Converts a 31-bit unsigned value to its digits in a base from 2 to 36 and
// sends one transfer per digit, most significant first, with tlast on the
// least significant digit. Each digit carries its value and its ASCII
// character (0-9, A-Z). A value of zero gives the single digit 0. A base
// outside 2..36 gives one transfer with tuser set, zero data and tlast set.
// One item is worked on at a time; s_tready is high only while the block is
// idle. The divider handles one quotient bit per cycle; each digit is then sent
// by a store read and then an output transfer that waits out any downstream
// stall. A bad base skips the division and the store read.
module radix_digit_converter_core (
	input  wire  logic                             clk,
	input  wire  logic                             arst_n,
	// value [30:0], radix [36:31], zero padding above
	input  wire  logic [rdc_pkg::InDataW-1:0]      s_tdata,
	input  wire  logic                             s_tvalid,
	output logic                                   s_tready,
	// digit_value [5:0], digit_char [12:6], zero padding above
	output logic [rdc_pkg::OutDataW-1:0]           m_tdata,
	// last_digit
	output logic                                   m_tlast,
	// bad_radix
	output logic                                   m_tuser,
	output logic                                   m_tvalid,
	input  wire  logic                             m_tready
);

	rdc_pkg::state_t                       state_q;
	logic [rdc_pkg::ValueBits-1:0]         quo_q;
	logic [rdc_pkg::DigitBits-1:0]         rem_q;
	logic [rdc_pkg::RadixBits-1:0]         radix_q;
	logic [rdc_pkg::BitCntW-1:0]           bit_cnt_q;
	logic [rdc_pkg::StoreAw-1:0]           cnt_q;
	logic [rdc_pkg::StoreAw-1:0]           idx_q;
	logic                                  bad_q;
	logic [rdc_pkg::DigitBits-1:0]         rd_q;

	logic [rdc_pkg::DigitBits-1:0]         store_mem [rdc_pkg::StoreDepth];

	logic [rdc_pkg::ValueBits-1:0]         in_value;
	logic [rdc_pkg::RadixBits-1:0]         in_radix;
	logic                                  in_xfer;
	logic                                  in_radix_ok;
	logic                                  out_xfer;
	logic [rdc_pkg::TrialW-1:0]            trial;
	logic                                  trial_ge;
	logic [rdc_pkg::TrialW-1:0]            trial_sub;
	logic [rdc_pkg::DigitBits-1:0]         rem_next;
	logic [rdc_pkg::ValueBits-1:0]         quo_next;
	logic                                  digit_done;
	logic [rdc_pkg::StoreAw-1:0]           cnt_next;
	logic                                  conv_done;
	logic [rdc_pkg::CharBits-1:0]          out_char;

	assign in_value    = s_tdata[rdc_pkg::ValueBits-1:0];
	assign in_radix    = s_tdata[rdc_pkg::ValueBits +: rdc_pkg::RadixBits];
	assign in_xfer     = s_tvalid && s_tready;
	assign out_xfer    = m_tvalid && m_tready;
	assign in_radix_ok = (in_radix >= rdc_pkg::RadixMin) && (in_radix <= rdc_pkg::RadixMax);

	// One restoring division step: bring in the next quotient bit
	assign trial     = {rem_q, quo_q[rdc_pkg::ValueBits-1]};
	assign trial_ge  = trial >= {1'b0, radix_q};
	assign trial_sub = trial - {1'b0, radix_q};
	assign rem_next  = trial_ge ? trial_sub[rdc_pkg::DigitBits-1:0]
	                            : trial[rdc_pkg::DigitBits-1:0];
	assign quo_next  = {quo_q[rdc_pkg::ValueBits-2:0], trial_ge};

	assign digit_done = (state_q == rdc_pkg::ST_DIV) && (bit_cnt_q == '0);
	assign cnt_next   = cnt_q + rdc_pkg::StoreAw'(1);
	assign conv_done  = (quo_next == '0) || (cnt_next == rdc_pkg::StoreAw'(rdc_pkg::MaxDigits));

	assign s_tready = (state_q == rdc_pkg::ST_IDLE);
	assign m_tvalid = (state_q == rdc_pkg::ST_OUT);
	assign out_char = rdc_pkg::digit_char(rd_q);
	assign m_tuser  = bad_q;
	assign m_tlast  = bad_q || (idx_q == '0);

	always_comb begin
		m_tdata = '0;
		if (!bad_q) begin
			m_tdata[rdc_pkg::DigitBits-1:0]                  = rd_q;
			m_tdata[rdc_pkg::DigitBits +: rdc_pkg::CharBits] = out_char;
		end
	end

	// Digit store: remainders go in at the digit count, come out from the top
	always_ff @(posedge clk) begin
		if (digit_done) begin
			store_mem[cnt_q] <= rem_next;
		end
		if (state_q == rdc_pkg::ST_RD) begin
			rd_q <= store_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rdc_pkg::ST_IDLE;
			quo_q     <= '0;
			rem_q     <= '0;
			radix_q   <= '0;
			bit_cnt_q <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			bad_q     <= 1'b0;
		end else begin
			unique case (state_q)
				rdc_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (in_radix_ok) begin
							quo_q     <= in_value;
							rem_q     <= '0;
							radix_q   <= in_radix;
							bit_cnt_q <= rdc_pkg::BitCntW'(rdc_pkg::ValueBits - 1);
							cnt_q     <= '0;
							bad_q     <= 1'b0;
							state_q   <= rdc_pkg::ST_DIV;
						end else begin
							bad_q   <= 1'b1;
							state_q <= rdc_pkg::ST_OUT;
						end
					end
				end
				rdc_pkg::ST_DIV: begin
					quo_q <= quo_next;
					if (bit_cnt_q == '0) begin
						cnt_q <= cnt_next;
						if (conv_done) begin
							idx_q   <= cnt_q;
							state_q <= rdc_pkg::ST_RD;
						end else begin
							// next digit: divide the quotient again from a clear remainder
							rem_q     <= '0;
							bit_cnt_q <= rdc_pkg::BitCntW'(rdc_pkg::ValueBits - 1);
						end
					end else begin
						rem_q     <= rem_next;
						bit_cnt_q <= bit_cnt_q - rdc_pkg::BitCntW'(1);
					end
				end
				rdc_pkg::ST_RD: begin
					state_q <= rdc_pkg::ST_OUT;
				end
				rdc_pkg::ST_OUT: begin
					if (out_xfer) begin
						if (bad_q || (idx_q == '0)) begin
							bad_q   <= 1'b0;
							state_q <= rdc_pkg::ST_IDLE;
						end else begin
							idx_q   <= idx_q - rdc_pkg::StoreAw'(1);
							state_q <= rdc_pkg::ST_RD;
						end
					end
				end
				default: begin
					state_q <= rdc_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is offered");

	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
		else $error("bad base result must be a single zero transfer");

	a_div_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rdc_pkg::ST_DIV) |->
			((radix_q >= rdc_pkg::RadixMin) && (radix_q <= rdc_pkg::RadixMax)))
		else $error("divider running with a base out of range");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block not idle after the final digit");
`endif

endmodule
`default_nettype wire

// File: sim/radix_digit_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_core_tb: self-checking bench for the digit converter
// Streams value/base requests into the core and predicts the digit transfers
// of each one, most significant first, then compares every output transfer
// with the oldest predicted digit under several source and sink idle patterns.
// ----------------------------------------------------------------------------
module radix_digit_converter_core_tb;

	localparam int ClkHalf      = 5;
	localparam int ResetCycles  = 10;
	localparam int TimeoutLimit = 3000000;
	localparam int HoldCycles   = 3000;
	localparam int DrainCycles  = 1100;
	localparam int PhaseItems   = 37;
	localparam int ShowLimit    = 10;

	localparam logic [rdc_pkg::CharBits-1:0] AsciiZero = rdc_pkg::CharBits'(48);
	localparam logic [rdc_pkg::CharBits-1:0] AsciiA    = rdc_pkg::CharBits'(65);
	localparam logic [rdc_pkg::ValueBits-1:0] ValueMax = '1;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SOURCE,
		IDLE_SINK,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [rdc_pkg::ValueBits-1:0] value;
		logic [rdc_pkg::RadixBits-1:0] radix;
	} request_t;

	typedef struct packed {
		logic [rdc_pkg::DigitBits-1:0] digit_val;
		logic [rdc_pkg::CharBits-1:0]  digit_chr;
		logic                          last;
		logic                          bad;
	} digit_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic [rdc_pkg::InDataW-1:0]  s_tdata  = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [rdc_pkg::OutDataW-1:0] m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;

	request_t    pending_requests[$];
	digit_t      expected_digits[$];
	idle_mode_t  idle_mode     = IDLE_NONE;
	logic        in_fire       = 1'b0;
	int unsigned hold_request  = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;
	int unsigned err_cnt       = 0;
	int unsigned cycle_cnt     = 0;

	radix_digit_converter_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	initial begin
		forever #ClkHalf clk = ~clk;
	end

	// Divide repeatedly, keep the remainders, then queue them most significant first
	task automatic queue_digits(input logic [rdc_pkg::ValueBits-1:0] value,
			input logic [rdc_pkg::RadixBits-1:0] radix);
		logic [rdc_pkg::DigitBits-1:0] remainders [0:rdc_pkg::MaxDigits];
		logic [rdc_pkg::ValueBits-1:0] quotient;
		int unsigned                   count;
		digit_t                        d;
		if (radix < rdc_pkg::RadixMin || radix > rdc_pkg::RadixMax) begin
			d = '{digit_val: '0, digit_chr: '0, last: 1'b1, bad: 1'b1};
			expected_digits.push_back(d);
			return;
		end
		count = 0;
		quotient = value;
		do begin
			remainders[count] = rdc_pkg::DigitBits'(quotient % radix);
			quotient = quotient / radix;
			count++;
		end while (quotient != '0 && count < rdc_pkg::MaxDigits);
		for (int k = int'(count) - 1; k >= 0; k--) begin
			d.digit_val = remainders[k];
			if (remainders[k] < rdc_pkg::DigitBits'(10)) begin
				d.digit_chr = AsciiZero + rdc_pkg::CharBits'(remainders[k]);
			end else begin
				d.digit_chr = AsciiA + rdc_pkg::CharBits'(remainders[k])
					- rdc_pkg::CharBits'(10);
			end
			d.last = (k == 0);
			d.bad  = 1'b0;
			expected_digits.push_back(d);
		end
	endtask

	function automatic request_t random_request();
		request_t          r;
		int unsigned       pick;
		int unsigned       steps;
		longint unsigned   p;
		pick = $urandom_range(99);
		if (pick < 85) begin
			r.radix = rdc_pkg::RadixBits'($urandom_range(36, 2));
		end else begin
			r.radix = rdc_pkg::RadixBits'($urandom_range(63, 0));
		end
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.value = rdc_pkg::ValueBits'($urandom);
		end else if (pick < 70) begin
			r.value = rdc_pkg::ValueBits'($urandom_range(1500));
		end else if (pick < 90) begin
			// power of the base, nudged by one to hit digit rollovers
			p = 1;
			steps = $urandom_range(30);
			for (int i = 0; i < steps && r.radix >= 2 && p * r.radix <= ValueMax; i++) begin
				p = p * r.radix;
			end
			r.value = rdc_pkg::ValueBits'(p + $urandom_range(2) - 1);
		end else if (pick < 95) begin
			r.value = '0;
		end else begin
			r.value = ValueMax;
		end
		return r;
	endfunction

	task automatic push_request(input logic [rdc_pkg::ValueBits-1:0] value,
			input logic [rdc_pkg::RadixBits-1:0] radix);
		request_t r;
		r.value = value;
		r.radix = radix;
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_digits.size() != 0);
	endtask

	// Source side: hold a request until its transfer, then offer the next or idle
	always @(negedge clk) begin : source_driver
		request_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_fire) begin
			s_tvalid <= 1'b1;
		end else if (pending_requests.size() != 0 &&
				!((idle_mode == IDLE_SOURCE && $urandom_range(99) < 81) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 12))) begin
			r = pending_requests.pop_front();
			s_tdata  <= rdc_pkg::InDataW'({r.radix, r.value});
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Sink side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin : sink_driver
		if (hold_served != hold_request) begin
			hold_served <= hold_request;
			hold_left   <= HoldCycles;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if ((idle_mode == IDLE_SINK && $urandom_range(99) < 81) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 12)) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		digit_t got;
		digit_t want;
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				queue_digits(s_tdata[rdc_pkg::ValueBits-1:0],
					s_tdata[rdc_pkg::ValueBits +: rdc_pkg::RadixBits]);
			end
			if (m_tvalid && m_tready) begin
				got.digit_val = m_tdata[rdc_pkg::DigitBits-1:0];
				got.digit_chr = m_tdata[rdc_pkg::DigitBits +: rdc_pkg::CharBits];
				got.last      = m_tlast;
				got.bad       = m_tuser;
				if (expected_digits.size() == 0) begin
					if (err_cnt < ShowLimit) begin
						$display("%0t: unexpected digit val=%0d chr=%0d last=%0b bad=%0b",
							$realtime, got.digit_val, got.digit_chr, got.last, got.bad);
					end
					err_cnt++;
				end else begin
					want = expected_digits.pop_front();
					if (got !== want) begin
						if (err_cnt < ShowLimit) begin
							$display("%0t: digit mismatch exp val=%0d chr=%0d last=%0b bad=%0b",
								$realtime, want.digit_val, want.digit_chr, want.last, want.bad);
							$display("%0t:                got val=%0d chr=%0d last=%0b bad=%0b",
								$realtime, got.digit_val, got.digit_chr, got.last, got.bad);
						end
						err_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > TimeoutLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero, extremes of value, digit letters and bad bases
		idle_mode = IDLE_NONE;
		push_request('0, rdc_pkg::RadixBits'(2));
		push_request('0, rdc_pkg::RadixBits'(36));
		push_request(ValueMax, rdc_pkg::RadixBits'(2));
		push_request(ValueMax, rdc_pkg::RadixBits'(36));
		push_request(ValueMax, rdc_pkg::RadixBits'(10));
		push_request(ValueMax, rdc_pkg::RadixBits'(16));
		push_request(rdc_pkg::ValueBits'(1), rdc_pkg::RadixBits'(2));
		push_request(rdc_pkg::ValueBits'(35), rdc_pkg::RadixBits'(36));
		push_request(rdc_pkg::ValueBits'(36), rdc_pkg::RadixBits'(36));
		push_request(rdc_pkg::ValueBits'(9), rdc_pkg::RadixBits'(10));
		push_request(rdc_pkg::ValueBits'(10), rdc_pkg::RadixBits'(11));
		push_request(rdc_pkg::ValueBits'(1000), rdc_pkg::RadixBits'(3));
		push_request(rdc_pkg::ValueBits'(49), rdc_pkg::RadixBits'(7));
		push_request(rdc_pkg::ValueBits'('h55555555), rdc_pkg::RadixBits'(2));
		push_request(rdc_pkg::ValueBits'('h2AAAAAAA), rdc_pkg::RadixBits'(2));
		push_request(rdc_pkg::ValueBits'(123), rdc_pkg::RadixBits'(0));
		push_request(rdc_pkg::ValueBits'(123), rdc_pkg::RadixBits'(1));
		push_request(rdc_pkg::ValueBits'(123), rdc_pkg::RadixBits'(37));
		push_request(ValueMax, rdc_pkg::RadixBits'(63));
		push_request('0, rdc_pkg::RadixBits'(1));
		push_request(rdc_pkg::ValueBits'(1295), rdc_pkg::RadixBits'(36));
		wait_drained();

		for (int m = 0; m < 4; m++) begin
			idle_mode = idle_mode_t'(m);
			repeat (PhaseItems) pending_requests.push_back(random_request());
			wait_drained();
		end

		// stall the sink long enough that the core backs up its input
		idle_mode = IDLE_NONE;
		hold_request++;
		repeat (12) pending_requests.push_back(random_request());
		wait_drained();

		repeat (DrainCycles) @(posedge clk);
		err_cnt += expected_digits.size();
		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
